FILE: sv/circular_bucket_priority_queue_defines.svh
// assertion helpers used by the queue datapath
// they rely on clk and arst_n being visible in the module that uses them
`ifndef CIRCULAR_BUCKET_PRIORITY_QUEUE_DEFINES_SVH
`define CIRCULAR_BUCKET_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define CBPQ_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cbpq same-cycle check failed");

// next-cycle implication
`define CBPQ_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cbpq next-cycle check failed");

`endif

FILE: sv/cbpq_pkg.sv
package cbpq_pkg;

	// sizes
	localparam int BUCKET_COUNT = 256;
	localparam int NODE_COUNT   = 1024;
	localparam int COST_BITS    = 24;
	localparam int NODE_BITS    = $clog2(NODE_COUNT);
	localparam int LINK_BITS    = NODE_BITS + 1;
	localparam int BKT_BITS     = $clog2(BUCKET_COUNT);
	localparam int SCAN_BITS    = BKT_BITS + 1;
	localparam int CNT_BITS     = NODE_BITS + 1;
	localparam int SPAN_BITS    = COST_BITS + 1;
	localparam int CW_BITS      = COST_BITS + 1;
	localparam int ERR_BITS     = 3;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(NODE_COUNT);
	localparam logic [COST_BITS-1:0] MAX_COST_RESET = {COST_BITS{1'b1}};

	// actions
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_DELMIN = 2'd2;

	// error codes
	localparam logic [ERR_BITS-1:0] ERR_OK         = 3'd0;
	localparam logic [ERR_BITS-1:0] ERR_COST_BIG   = 3'd1;
	localparam logic [ERR_BITS-1:0] ERR_RANGE      = 3'd2;
	localparam logic [ERR_BITS-1:0] ERR_QUEUED     = 3'd3;
	localparam logic [ERR_BITS-1:0] ERR_NOT_QUEUED = 3'd4;
	localparam logic [ERR_BITS-1:0] ERR_WINDOW     = 3'd5;
	localparam logic [ERR_BITS-1:0] ERR_EMPTY      = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TIE_BREAK = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_COST  = 1'b1;

	typedef struct packed {
		logic [1:0]           action;
		logic [NODE_BITS-1:0] node_id;
		logic [COST_BITS-1:0] cost;
		logic                 cost_infinite;
	} in_word_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] out_node;
		logic [COST_BITS-1:0] out_cost;
		logic                 out_infinite;
		logic                 queue_empty;
		logic [ERR_BITS-1:0]  error;
	} out_word_t;

	typedef struct packed {
		logic [CFG_IDX_BITS-1:0] index;
		logic [COST_BITS-1:0]    value;
	} cfg_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_TRIM_RD, ST_TRIM_CHK, ST_SCAN_RD, ST_SCAN_CHK,
		ST_READ_P, ST_EVAL, ST_INS_A, ST_INS_B, ST_REM_B, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLEAR, OP_LOAD, OP_SETUP, OP_TRIM_STEP, OP_TRIM_FIX, OP_SCAN_STEP,
		OP_SCAN_TAKE, OP_INS_NEW, OP_INS_EVAL, OP_INS_A, OP_INS_B, OP_REM_EVAL, OP_REM_B,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic                err_load;
		logic [ERR_BITS-1:0] err_code;
		logic                in_ready;
	} cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       inf;
		logic       too_big;
		logic       fcount_zero;
		logic       inf_head_nil;
		logic       below;
		logic       above;
		logic       trim_ok;
		logic       k_end;
		logic       head_rd_nil;
		logic       np_nil;
		logic       np_is_p;
		logic       h_nil;
		logic       mismatch;
		logic       clear_last;
		logic       out_busy;
		logic       in_valid;
	} stat_t;

endpackage

FILE: sv/cbpq_chan_if.sv
// valid/ready channel carrying one word
interface cbpq_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cbpq_ctrl.sv
module cbpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  cbpq_pkg::stat_t stat,
	output cbpq_pkg::cmd_t  cmd
);
	import cbpq_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (stat.in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				case (stat.act)
					ACT_INSERT: begin
						if (!stat.inf && stat.too_big) state_d = ST_DONE;
						else if (!stat.inf && !stat.fcount_zero && (stat.below || stat.above))
							state_d = ST_TRIM_RD;
						else state_d = ST_READ_P;
					end
					ACT_DELETE: begin
						if (stat.inf) state_d = stat.inf_head_nil ? ST_DONE : ST_READ_P;
						else if (stat.fcount_zero || stat.below || stat.above) state_d = ST_DONE;
						else state_d = ST_READ_P;
					end
					ACT_DELMIN: begin
						if (!stat.fcount_zero) state_d = ST_SCAN_RD;
						else state_d = stat.inf_head_nil ? ST_DONE : ST_READ_P;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_TRIM_RD: begin
				if (stat.trim_ok) state_d = ST_READ_P;
				else if (stat.k_end) state_d = ST_DONE;
				else state_d = ST_TRIM_CHK;
			end
			ST_TRIM_CHK: begin
				state_d = stat.head_rd_nil ? ST_TRIM_RD : ST_DONE;
			end
			ST_SCAN_RD: begin
				state_d = stat.k_end ? ST_DONE : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				state_d = stat.head_rd_nil ? ST_SCAN_RD : ST_READ_P;
			end
			ST_READ_P: state_d = ST_EVAL;
			ST_EVAL: begin
				case (stat.act)
					ACT_INSERT: begin
						if (!stat.np_nil || stat.h_nil) state_d = ST_DONE;
						else state_d = ST_INS_A;
					end
					ACT_DELETE: begin
						if (stat.np_nil || stat.mismatch || stat.np_is_p) state_d = ST_DONE;
						else state_d = ST_REM_B;
					end
					ACT_DELMIN: state_d = stat.np_is_p ? ST_DONE : ST_REM_B;
					default: state_d = ST_DONE;
				endcase
			end
			ST_INS_A: state_d = ST_INS_B;
			ST_INS_B: state_d = ST_DONE;
			ST_REM_B: state_d = ST_DONE;
			ST_DONE: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.err_code = ERR_OK;
		case (state_q)
			ST_CLEAR: cmd.op = OP_CLEAR;
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) cmd.op = OP_LOAD;
			end
			ST_CHECK: begin
				case (stat.act)
					ACT_INSERT: begin
						if (!stat.inf && stat.too_big) begin
							cmd.err_load = 1'b1;
							cmd.err_code = ERR_COST_BIG;
						end else begin
							cmd.op = OP_SETUP;
						end
					end
					ACT_DELETE: begin
						if (stat.inf) begin
							if (stat.inf_head_nil) begin
								cmd.err_load = 1'b1;
								cmd.err_code = ERR_NOT_QUEUED;
							end else begin
								cmd.op = OP_SETUP;
							end
						end else if (stat.fcount_zero) begin
							cmd.err_load = 1'b1;
							cmd.err_code = ERR_NOT_QUEUED;
						end else if (stat.below || stat.above) begin
							cmd.err_load = 1'b1;
							cmd.err_code = ERR_WINDOW;
						end else begin
							cmd.op = OP_SETUP;
						end
					end
					ACT_DELMIN: begin
						if (stat.fcount_zero && stat.inf_head_nil) begin
							cmd.err_load = 1'b1;
							cmd.err_code = ERR_EMPTY;
						end else begin
							cmd.op = OP_SETUP;
						end
					end
					default: ;
				endcase
			end
			ST_TRIM_RD: begin
				if (stat.trim_ok) begin
					cmd.op = OP_TRIM_FIX;
				end else if (stat.k_end) begin
					cmd.err_load = 1'b1;
					cmd.err_code = ERR_RANGE;
				end
			end
			ST_TRIM_CHK: begin
				if (stat.head_rd_nil) begin
					cmd.op = OP_TRIM_STEP;
				end else begin
					cmd.err_load = 1'b1;
					cmd.err_code = ERR_RANGE;
				end
			end
			ST_SCAN_RD: begin
				if (stat.k_end) begin
					cmd.err_load = 1'b1;
					cmd.err_code = ERR_EMPTY;
				end
			end
			ST_SCAN_CHK: cmd.op = stat.head_rd_nil ? OP_SCAN_STEP : OP_SCAN_TAKE;
			ST_EVAL: begin
				case (stat.act)
					ACT_INSERT: begin
						if (!stat.np_nil) begin
							cmd.err_load = 1'b1;
							cmd.err_code = ERR_QUEUED;
						end else begin
							cmd.op = stat.h_nil ? OP_INS_NEW : OP_INS_EVAL;
						end
					end
					ACT_DELETE: begin
						if (stat.np_nil) begin
							cmd.err_load = 1'b1;
							cmd.err_code = ERR_NOT_QUEUED;
						end else if (stat.mismatch) begin
							cmd.err_load = 1'b1;
							cmd.err_code = ERR_WINDOW;
						end else begin
							cmd.op = OP_REM_EVAL;
						end
					end
					ACT_DELMIN: cmd.op = OP_REM_EVAL;
					default: ;
				endcase
			end
			ST_INS_A: cmd.op = OP_INS_A;
			ST_INS_B: cmd.op = OP_INS_B;
			ST_REM_B: cmd.op = OP_REM_B;
			ST_DONE: begin
				if (!stat.out_busy) cmd.op = OP_FINISH;
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/cbpq_dp.sv
module cbpq_dp (
	input  logic           clk,
	input  logic           arst_n,
	cbpq_chan_if.sink      req,
	cbpq_chan_if.source    rsp,
	cbpq_chan_if.sink      cfg,
	input  cbpq_pkg::cmd_t cmd,
	output cbpq_pkg::stat_t stat
);
	import cbpq_pkg::*;

	// memories
	logic [LINK_BITS-1:0] next_mem [NODE_COUNT];
	logic [LINK_BITS-1:0] prev_mem [NODE_COUNT];
	logic [CW_BITS-1:0]   cost_mem [NODE_COUNT];
	logic [LINK_BITS-1:0] head_mem [BUCKET_COUNT];

	logic [LINK_BITS-1:0] next_rd_q, prev_rd_q, head_rd_q;
	logic [CW_BITS-1:0]   cost_rd_q;

	logic                 next_we, prev_we, cost_we, head_we, head_wr, head_clr;
	logic [NODE_BITS-1:0] next_wa, prev_wa, prev_ra;
	logic [LINK_BITS-1:0] next_wd, prev_wd, head_wd, head_wd_m;
	logic [BKT_BITS-1:0]  head_wa;
	logic [CW_BITS-1:0]   cost_wd;

	// item registers
	logic [1:0]           act_q;
	logic [NODE_BITS-1:0] p_q;
	logic [COST_BITS-1:0] c_q;
	logic                 inf_q;
	logic [ERR_BITS-1:0]  err_q;
	logic [BKT_BITS-1:0]  idx_q;
	logic [SCAN_BITS-1:0] k_q;
	logic [SPAN_BITS-1:0] nb_q;
	logic                 dir_q;
	logic [COST_BITS-1:0] nlo_q, nhi_q;
	logic [LINK_BITS-1:0] np_q, bp_q, hv_q, back_q;
	logic [CW_BITS-1:0]   cp_q;

	// queue state and configuration
	logic [COST_BITS-1:0] low_q, high_q, maxc_q;
	logic [CNT_BITS-1:0]  fcount_q;
	logic [LINK_BITS-1:0] inf_head_q;
	logic                 tie_q;
	logic [NODE_BITS-1:0] clr_q;
	logic                 out_valid_q;
	out_word_t            out_q;

	logic [LINK_BITS-1:0] h_cur, p_link;
	logic                 deleting;

	// setup values for a new word
	logic [BKT_BITS-1:0]  su_idx;
	logic [COST_BITS-1:0] su_nlo, su_nhi;
	logic [SPAN_BITS-1:0] su_nb;

	assign p_link   = {1'b0, p_q};
	assign h_cur    = inf_q ? inf_head_q : head_rd_q;
	assign cost_wd  = {inf_q, inf_q ? {COST_BITS{1'b0}} : c_q};
	assign deleting = (act_q == ACT_DELETE) || (act_q == ACT_DELMIN);

	// status to the controller
	always_comb begin
		stat              = '0;
		stat.act          = act_q;
		stat.inf          = inf_q;
		stat.too_big      = c_q > maxc_q;
		stat.fcount_zero  = fcount_q == '0;
		stat.inf_head_nil = inf_head_q == NIL;
		stat.below        = c_q < low_q;
		stat.above        = c_q > high_q;
		stat.trim_ok      = nb_q <= SPAN_BITS'(BUCKET_COUNT);
		stat.k_end        = k_q == SCAN_BITS'(BUCKET_COUNT);
		stat.head_rd_nil  = head_rd_q == NIL;
		stat.np_nil       = next_rd_q == NIL;
		stat.np_is_p      = next_rd_q == p_link;
		stat.h_nil        = h_cur == NIL;
		stat.mismatch     = inf_q ? !cost_rd_q[COST_BITS]
			: (cost_rd_q[COST_BITS] || (cost_rd_q[COST_BITS-1:0] != c_q));
		stat.clear_last   = clr_q == NODE_BITS'(NODE_COUNT - 1);
		stat.out_busy     = out_valid_q && !rsp.ready;
		stat.in_valid     = req.valid;
	end

	assign req.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// window, span and first bucket for the word just loaded
	always_comb begin
		su_idx = c_q[BKT_BITS-1:0];
		su_nlo = low_q;
		su_nhi = high_q;
		su_nb  = '0;
		if (act_q == ACT_INSERT && !inf_q) begin
			if (fcount_q == '0) begin
				su_nlo = c_q;
				su_nhi = c_q;
			end else if (c_q < low_q) begin
				su_nb  = {1'b0, high_q} - {1'b0, c_q} + 1'b1;
				su_idx = high_q[BKT_BITS-1:0];
			end else if (c_q > high_q) begin
				su_nb  = {1'b0, c_q} - {1'b0, low_q} + 1'b1;
				su_idx = low_q[BKT_BITS-1:0];
			end
		end
		if (act_q == ACT_DELMIN) su_idx = low_q[BKT_BITS-1:0];
	end

	// memory write and read addressing
	always_comb begin
		next_we  = 1'b0;
		next_wa  = p_q;
		next_wd  = NIL;
		prev_we  = 1'b0;
		prev_wa  = p_q;
		prev_wd  = NIL;
		prev_ra  = p_q;
		cost_we  = 1'b0;
		head_wr  = 1'b0;
		head_wd  = NIL;
		head_clr = 1'b0;
		case (cmd.op)
			OP_CLEAR: begin
				next_we  = 1'b1;
				next_wa  = clr_q;
				prev_we  = 1'b1;
				prev_wa  = clr_q;
				head_clr = 1'b1;
			end
			OP_INS_NEW: begin
				cost_we = 1'b1;
				next_we = 1'b1;
				next_wd = p_link;
				prev_we = 1'b1;
				prev_wd = p_link;
				head_wr = 1'b1;
				head_wd = p_link;
			end
			OP_INS_EVAL: begin
				cost_we = 1'b1;
				prev_ra = h_cur[NODE_BITS-1:0];
			end
			OP_INS_A: begin
				next_we = 1'b1;
				next_wd = hv_q;
				prev_we = 1'b1;
				prev_wd = prev_rd_q;
			end
			OP_INS_B: begin
				prev_we = 1'b1;
				prev_wa = hv_q[NODE_BITS-1:0];
				prev_wd = p_link;
				next_we = 1'b1;
				next_wa = back_q[NODE_BITS-1:0];
				next_wd = p_link;
				head_wr = tie_q;
				head_wd = p_link;
			end
			OP_REM_EVAL: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				head_wr = next_rd_q == p_link;
			end
			OP_REM_B: begin
				prev_we = 1'b1;
				prev_wa = np_q[NODE_BITS-1:0];
				prev_wd = bp_q;
				next_we = 1'b1;
				next_wa = bp_q[NODE_BITS-1:0];
				next_wd = np_q;
				head_wr = hv_q == p_link;
				head_wd = np_q;
			end
			default: ;
		endcase
	end

	assign head_we   = head_clr || (head_wr && !inf_q);
	assign head_wa   = head_clr ? clr_q[BKT_BITS-1:0] : idx_q;
	assign head_wd_m = head_clr ? NIL : head_wd;

	// link, cost and bucket head memories
	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[prev_ra];
	end

	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[p_q] <= cost_wd;
		cost_rd_q <= cost_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd_m;
		head_rd_q <= head_mem[idx_q];
	end

	// queue state, configuration, clear counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= '0;
			fcount_q    <= '0;
			inf_head_q  <= NIL;
			tie_q       <= 1'b0;
			maxc_q      <= MAX_COST_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					REG_TIE_BREAK: tie_q <= cfg.data.value[0];
					REG_MAX_COST: maxc_q <= cfg.data.value;
					default: ;
				endcase
			end
			if (cmd.op == OP_CLEAR) clr_q <= clr_q + 1'b1;
			if (head_wr && inf_q) inf_head_q <= head_wd;
			if ((cmd.op == OP_INS_NEW || cmd.op == OP_INS_B) && !inf_q) begin
				fcount_q <= fcount_q + 1'b1;
				low_q    <= nlo_q;
				high_q   <= nhi_q;
			end
			if (cmd.op == OP_REM_EVAL && !inf_q) begin
				fcount_q <= fcount_q - 1'b1;
				if (act_q == ACT_DELMIN) low_q <= cost_rd_q[COST_BITS-1:0];
			end
			if (cmd.op == OP_FINISH) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		if (cmd.err_load) err_q <= cmd.err_code;
		case (cmd.op)
			OP_LOAD: begin
				act_q <= req.data.action;
				p_q   <= req.data.node_id;
				c_q   <= req.data.cost;
				inf_q <= req.data.cost_infinite;
				err_q <= ERR_OK;
			end
			OP_SETUP: begin
				idx_q <= su_idx;
				k_q   <= '0;
				nlo_q <= su_nlo;
				nhi_q <= su_nhi;
				dir_q <= c_q < low_q;
				nb_q  <= su_nb;
				if (act_q == ACT_DELMIN) begin
					inf_q <= fcount_q == '0;
					p_q   <= inf_head_q[NODE_BITS-1:0];
				end
			end
			OP_TRIM_STEP: begin
				nb_q  <= nb_q - 1'b1;
				idx_q <= dir_q ? idx_q - 1'b1 : idx_q + 1'b1;
				k_q   <= k_q + 1'b1;
			end
			OP_TRIM_FIX: begin
				idx_q <= c_q[BKT_BITS-1:0];
				if (dir_q) begin
					nlo_q <= c_q;
					nhi_q <= c_q + nb_q[COST_BITS-1:0] - 1'b1;
				end else begin
					nlo_q <= c_q - (nb_q[COST_BITS-1:0] - 1'b1);
					nhi_q <= c_q;
				end
			end
			OP_SCAN_STEP: begin
				idx_q <= idx_q + 1'b1;
				k_q   <= k_q + 1'b1;
			end
			OP_SCAN_TAKE: p_q <= head_rd_q[NODE_BITS-1:0];
			OP_INS_EVAL: hv_q <= h_cur;
			OP_INS_A: back_q <= prev_rd_q;
			OP_REM_EVAL: begin
				np_q <= next_rd_q;
				bp_q <= prev_rd_q;
				hv_q <= h_cur;
				cp_q <= cost_rd_q;
			end
			default: ;
		endcase
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINISH) begin
			out_q.out_node     <= (act_q == ACT_DELMIN && err_q != ERR_OK) ? '0 : p_q;
			out_q.out_cost     <= (deleting && err_q == ERR_OK) ? cp_q[COST_BITS-1:0] : '0;
			out_q.out_infinite <= deleting && err_q == ERR_OK && cp_q[COST_BITS];
			out_q.queue_empty  <= fcount_q == '0 && inf_head_q == NIL;
			out_q.error        <= err_q;
		end
	end

	`include "circular_bucket_priority_queue_defines.svh"

	`CBPQ_ASSERT_IMPL(a_window_order, fcount_q != '0, low_q <= high_q)
	`CBPQ_ASSERT_IMPL(a_window_span, fcount_q != '0, (high_q - low_q) < COST_BITS'(BUCKET_COUNT))
	`CBPQ_ASSERT_IMPL(a_count_bound, 1'b1, fcount_q <= CNT_BITS'(NODE_COUNT))
	`CBPQ_ASSERT_NEXT(a_finish_valid, cmd.op == OP_FINISH, out_valid_q)

endmodule

FILE: sv/circular_bucket_priority_queue.sv
// channel  dir  word        handshake
// req      in   in_word_t   req.valid / req.ready
// rsp      out  out_word_t  rsp.valid / rsp.ready
// cfg      in   cfg_word_t  cfg.valid / cfg.ready (always ready)
//
// the result is set by the registered link, cost and bucket head reads and up to two link write
// passes; errors finish early, and the next word is taken once the result is loaded.
// window trimming and the delete-min bucket search read and check each bucket visited in turn.
// after reset a clearing pass sets all links and bucket heads to null; no word is taken
// meanwhile, configuration writes are; a stalled result holds the next one
module circular_bucket_priority_queue (
	input logic         clk,
	input logic         arst_n,
	cbpq_chan_if.sink   req,
	cbpq_chan_if.source rsp,
	cbpq_chan_if.sink   cfg
);
	import cbpq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	cbpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// memories, window registers and result register
	cbpq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

FILE: tb/sv/cbpq_queue_checker.sv
// watches the request, result and register channels, predicts each result word
module cbpq_queue_checker
	import cbpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  in_word_t  req_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  out_word_t rsp_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  cfg_word_t cfg_data,
	output int        fail_count,
	output int        pending,
	output int        words_seen
);

	// model of the bucket rings
	logic [LINK_BITS-1:0] head_of [BUCKET_COUNT];
	logic [LINK_BITS-1:0] inf_head;
	logic [LINK_BITS-1:0] fwd [NODE_COUNT];
	logic [LINK_BITS-1:0] back [NODE_COUNT];
	logic [COST_BITS-1:0] stored_cost [NODE_COUNT];
	logic                 stored_inf [NODE_COUNT];
	logic [COST_BITS-1:0] lo_cost, hi_cost;
	int                   live_count;
	logic                 lifo;
	logic [COST_BITS-1:0] cost_limit;
	out_word_t            result_fifo [$];

	initial begin
		fail_count = 0;
		words_seen = 0;
		pending = 0;
		for (int i = 0; i < BUCKET_COUNT; i++) head_of[i] = NIL;
		for (int i = 0; i < NODE_COUNT; i++) begin
			fwd[i] = NIL;
			back[i] = NIL;
			stored_cost[i] = '0;
			stored_inf[i] = 1'b0;
		end
		inf_head = NIL;
		lo_cost = '0;
		hi_cost = '0;
		live_count = 0;
		lifo = 1'b0;
		cost_limit = MAX_COST_RESET;
	end

	// ring of bucket bkt, or of the infinite bucket when bkt is negative
	function automatic void ring_link(int bkt, int p);
		logic [LINK_BITS-1:0] h;
		int f, b;
		h = (bkt < 0) ? inf_head : head_of[bkt];
		if (h == NIL) begin
			h = LINK_BITS'(p);
			fwd[p] = LINK_BITS'(p);
			back[p] = LINK_BITS'(p);
		end else begin
			f = int'(h);
			b = int'(back[f]);
			fwd[p] = LINK_BITS'(f);
			back[p] = LINK_BITS'(b);
			back[f] = LINK_BITS'(p);
			fwd[b] = LINK_BITS'(p);
			if (lifo) h = LINK_BITS'(p);
		end
		if (bkt < 0) inf_head = h;
		else head_of[bkt] = h;
	endfunction

	function automatic void ring_unlink(int bkt, int p);
		logic [LINK_BITS-1:0] h;
		int n, b;
		h = (bkt < 0) ? inf_head : head_of[bkt];
		if (fwd[p] == p) begin
			h = NIL;
		end else begin
			n = int'(fwd[p]);
			b = int'(back[p]);
			if (h == p) h = LINK_BITS'(n);
			back[n] = LINK_BITS'(b);
			fwd[b] = LINK_BITS'(n);
		end
		fwd[p] = NIL;
		back[p] = NIL;
		if (bkt < 0) inf_head = h;
		else head_of[bkt] = h;
	endfunction

	function automatic logic [ERR_BITS-1:0] insert_node(int p, longint c, logic inf);
		longint nlo, nhi, nb;
		int edge_b;
		nlo = lo_cost;
		nhi = hi_cost;
		if (!inf) begin
			if (c > cost_limit) return ERR_COST_BIG;
			if (live_count == 0) begin
				nlo = c;
				nhi = c;
			end else if (c < lo_cost) begin
				nb = hi_cost - c + 1;
				edge_b = int'(hi_cost % BUCKET_COUNT);
				for (int k = 0; k < BUCKET_COUNT && nb > BUCKET_COUNT
						&& head_of[edge_b] == NIL; k++) begin
					nb--;
					edge_b = (edge_b + BUCKET_COUNT - 1) % BUCKET_COUNT;
				end
				if (nb > BUCKET_COUNT) return ERR_RANGE;
				nlo = c;
				nhi = c + nb - 1;
			end else if (c > hi_cost) begin
				nb = c - lo_cost + 1;
				edge_b = int'(lo_cost % BUCKET_COUNT);
				for (int k = 0; k < BUCKET_COUNT && nb > BUCKET_COUNT
						&& head_of[edge_b] == NIL; k++) begin
					nb--;
					edge_b = (edge_b + 1) % BUCKET_COUNT;
				end
				if (nb > BUCKET_COUNT) return ERR_RANGE;
				nhi = c;
				nlo = c - (nb - 1);
			end
		end
		if (fwd[p] != NIL) return ERR_QUEUED;
		stored_inf[p] = inf;
		stored_cost[p] = inf ? '0 : c[COST_BITS-1:0];
		if (inf) begin
			ring_link(-1, p);
		end else begin
			lo_cost = COST_BITS'(nlo);
			hi_cost = COST_BITS'(nhi);
			live_count++;
			ring_link(int'(c % BUCKET_COUNT), p);
		end
		return ERR_OK;
	endfunction

	function automatic logic [ERR_BITS-1:0] delete_node(int p, longint c, logic inf);
		if (inf) begin
			if (inf_head == NIL) return ERR_NOT_QUEUED;
			if (fwd[p] == NIL) return ERR_NOT_QUEUED;
			if (!stored_inf[p]) return ERR_WINDOW;
			ring_unlink(-1, p);
		end else begin
			if (live_count == 0) return ERR_NOT_QUEUED;
			if (c < lo_cost || c > hi_cost) return ERR_WINDOW;
			if (fwd[p] == NIL) return ERR_NOT_QUEUED;
			if (stored_inf[p] || stored_cost[p] != c) return ERR_WINDOW;
			live_count--;
			ring_unlink(int'(c % BUCKET_COUNT), p);
		end
		return ERR_OK;
	endfunction

	function automatic out_word_t predict_result(in_word_t w);
		out_word_t r;
		int p, q, b;
		r = '0;
		r.out_node = w.node_id;
		p = int'(w.node_id);
		case (w.action)
			ACT_INSERT: begin
				r.error = insert_node(p, longint'(w.cost), w.cost_infinite);
			end
			ACT_DELETE: begin
				r.error = delete_node(p, longint'(w.cost), w.cost_infinite);
				if (r.error == ERR_OK) begin
					r.out_cost = stored_cost[p];
					r.out_infinite = stored_inf[p];
				end
			end
			ACT_DELMIN: begin
				q = NIL;
				r.out_node = '0;
				if (live_count == 0) begin
					if (inf_head != NIL) begin
						q = int'(inf_head);
						ring_unlink(-1, q);
					end
				end else begin
					for (int k = 0; k < BUCKET_COUNT; k++) begin
						b = int'((lo_cost % BUCKET_COUNT + k) % BUCKET_COUNT);
						if (head_of[b] != NIL) begin
							q = int'(head_of[b]);
							lo_cost = stored_cost[q];
							live_count--;
							ring_unlink(b, q);
							break;
						end
					end
				end
				if (q == NIL) begin
					r.error = ERR_EMPTY;
				end else begin
					r.out_node = NODE_BITS'(q);
					r.out_cost = stored_cost[q];
					r.out_infinite = stored_inf[q];
				end
			end
			default: ;
		endcase
		r.queue_empty = (live_count == 0 && inf_head == NIL);
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	// predict on each accepted request word, compare each accepted result word
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_data.index == REG_TIE_BREAK) lifo = cfg_data.value[0];
				else cost_limit = cfg_data.value;
			end
			if (rsp_valid && rsp_ready) begin
				words_seen++;
				if (result_fifo.size() == 0) begin
					report("unexpected word node", rsp_data.out_node, 0);
				end else begin
					e = result_fifo.pop_front();
					if (rsp_data.out_node !== e.out_node)
						report("out_node", rsp_data.out_node, e.out_node);
					if (rsp_data.out_cost !== e.out_cost)
						report("out_cost", rsp_data.out_cost, e.out_cost);
					if (rsp_data.out_infinite !== e.out_infinite)
						report("out_infinite", rsp_data.out_infinite, e.out_infinite);
					if (rsp_data.queue_empty !== e.queue_empty)
						report("queue_empty", rsp_data.queue_empty, e.queue_empty);
					if (rsp_data.error !== e.error)
						report("error", rsp_data.error, e.error);
				end
			end
			if (req_valid && req_ready)
				result_fifo.push_back(predict_result(req_data));
			pending = result_fifo.size();
		end
	end

endmodule

FILE: tb/sv/tb_circular_bucket_priority_queue.sv
module tb_circular_bucket_priority_queue;
	import cbpq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle = 0;
	int   fails, pending, words_seen;
	int   sent = 0;
	int   held [$];
	logic [COST_BITS-1:0] base_cost = '0;

	cbpq_chan_if #(.T(in_word_t))  req ();
	cbpq_chan_if #(.T(out_word_t)) rsp ();
	cbpq_chan_if #(.T(cfg_word_t)) cfg ();

	circular_bucket_priority_queue dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	cbpq_queue_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_data(cfg.data),
		.fail_count(fails), .pending(pending), .words_seen(words_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 3000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		rsp.ready = 1'b0;
	end

	// result side stalls a random number of cycles per word
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	// valid stays up after the accept until the next word or an idle period
	task automatic send_word(logic [1:0] act, int node, logic [COST_BITS-1:0] c, logic inf,
			bit no_gap = 0);
		int gap;
		gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.data <= '{action: act, node_id: node[NODE_BITS-1:0], cost: c,
			cost_infinite: inf};
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COST_BITS-1:0] v);
		cfg.data <= '{index: idx, value: v};
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, wait for all results, then idle before returning
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// picks a node sent in an earlier insert for a delete, or a random node
	task automatic random_word();
		int r, node, idx;
		logic [COST_BITS-1:0] c;
		r = $urandom_range(0, 99);
		c = COST_BITS'(base_cost + $urandom_range(0, 300));
		node = $urandom_range(0, NODE_COUNT - 1);
		if (r < 45) begin
			send_word(ACT_INSERT, node, c, $urandom_range(0, 9) == 0);
			held.push_back(node);
		end else if (r < 60 && held.size() > 0) begin
			idx = $urandom_range(0, held.size() - 1);
			send_word(ACT_DELETE, held[idx], c, $urandom_range(0, 5) == 0);
		end else if (r < 90) begin
			send_word(ACT_DELMIN, node, c, 1'b0);
			if ($urandom_range(0, 15) == 0)
				base_cost = COST_BITS'(base_cost + $urandom_range(1, 400));
		end else begin
			send_word(2'($urandom_range(0, 3)), node, 24'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every action and every error path but the cost limit
		send_word(ACT_DELMIN, 0, '0, 1'b0);
		send_word(ACT_DELETE, 5, 24'd10, 1'b0);
		send_word(ACT_DELETE, 5, 24'd0, 1'b1);
		send_word(ACT_INSERT, 0, 24'd100, 1'b0);
		send_word(ACT_INSERT, 0, 24'd100, 1'b0);
		send_word(ACT_INSERT, 1023, 24'd355, 1'b0);
		send_word(ACT_INSERT, 7, 24'd356, 1'b0);
		send_word(ACT_INSERT, 8, 24'd0, 1'b0);
		send_word(ACT_INSERT, 9, 24'hFFFFFF, 1'b1);
		send_word(ACT_INSERT, 10, 24'hFFFFFF, 1'b0);
		send_word(ACT_DELETE, 9, 24'd0, 1'b0);
		send_word(ACT_DELETE, 0, 24'd50, 1'b0);
		send_word(ACT_DELETE, 0, 24'd101, 1'b0);
		send_word(ACT_DELETE, 1023, 24'd0, 1'b1);
		send_word(ACT_DELETE, 2, 24'd100, 1'b0);
		send_word(ACT_DELETE, 0, 24'd100, 1'b0, 1);
		send_word(2'd3, 1023, 24'hFFFFFF, 1'b1, 1);
		send_word(ACT_INSERT, 11, 24'd120, 1'b0, 1);
		send_word(ACT_INSERT, 12, 24'd120, 1'b0, 1);
		repeat (5) send_word(ACT_DELMIN, 0, '0, 1'b0);
		drain();

		// cost limit 0, then fifo and lifo by turns with limits 2000 and max
		write_reg(REG_MAX_COST, 24'd0);
		send_word(ACT_INSERT, 3, 24'd1, 1'b0);
		send_word(ACT_INSERT, 3, 24'd0, 1'b0);
		send_word(ACT_DELMIN, 0, '0, 1'b0);
		drain();
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_TIE_BREAK, COST_BITS'(phase[0]));
			write_reg(REG_MAX_COST, phase == 2 ? 24'd2000 : 24'hFFFFFF);
			if (phase == 3) base_cost = 24'hFFFE00;
			held.delete();
			for (int i = 0; i < 210; i++) random_word();
			drain();
		end

		$display("covered %0d words in fifo and lifo order with cost limits 0, 2000 and max",
			sent);
		$display("%0d result words checked", words_seen);
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
